// ===== rtl/double_array_trie_keyword_scanner_macros.svh =====
// ----------------------------------------------------------------------------
// Keyword scanner assertion macros
// Concurrent check helpers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ARRAY_TRIE_KEYWORD_SCANNER_MACROS_SVH
`define DOUBLE_ARRAY_TRIE_KEYWORD_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// a implies b in the same cycle
`define DATKS_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("scanner check failed");
// a implies b in the next cycle
`define DATKS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("scanner check failed");
`else
`define DATKS_ASSERT_NOW(label, clk, rst_n, a, b)
`define DATKS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/datks_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyword scanner package
// Shared constants, item and table entry types, sequencer states.
// ----------------------------------------------------------------------------
package datks_pkg;
	localparam int TABLE_DEPTH_DEF = 65536;
	localparam int MAX_KEY_DEF     = 32;
	localparam int CHAR_BITS       = 16;
	localparam int POSITION_BITS   = 20;
	localparam int LEN_BITS        = 6;
	localparam int BASE_BITS       = 17;
	localparam int CHECK_BITS      = 16;
	localparam int IDX_BITS        = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int IN_DATA_BITS    = 72;
	localparam int OUT_DATA_BITS   = 32;

	// one trie table entry
	typedef struct packed {
		logic signed [BASE_BITS-1:0] base;
		logic [CHECK_BITS-1:0]       check;
	} entry_t;

	// classified input word
	typedef struct packed {
		logic                        is_text;
		logic                        idx_ok;
		logic [IDX_BITS-1:0]         index;
		logic signed [BASE_BITS-1:0] base;
		logic [CHECK_BITS-1:0]       check;
		logic [CHAR_BITS-1:0]        chr;
		logic                        eot;
	} item_t;

	// back end to front end control
	typedef struct packed {
		logic pop;
		logic clearing;
	} ctl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADV,
		ST_STEP,
		ST_TERM,
		ST_RESOLVE,
		ST_FINISH
	} state_t;
endpackage

// ===== rtl/datks_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module datks_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/datks_front.sv =====
// ----------------------------------------------------------------------------
// Keyword scanner front end
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module datks_front #(
	parameter int TABLE_DEPTH = datks_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [datks_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input  logic                                 s_tuser,
	input  logic                                 s_tlast,
	input  datks_pkg::ctl_t                      ctl,
	output logic                                 q_valid,
	output datks_pkg::item_t                     q_item
);
	import datks_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);

	item_t         fifo_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [QW:0]   fill_q;
	item_t         in_item;
	logic          push;
	logic          pop;

	// classify the incoming word
	always_comb begin
		in_item.is_text = s_tuser;
		in_item.index   = s_tdata[15:0];
		in_item.idx_ok  = (32'(s_tdata[15:0]) < 32'(TABLE_DEPTH));
		in_item.base    = $signed(s_tdata[32:16]);
		in_item.check   = s_tdata[48:33];
		in_item.chr     = s_tdata[49 +: CHAR_BITS];
		in_item.eot     = s_tlast;
	end

	assign s_tready = (fill_q != (QW+1)'(QUEUE_DEPTH)) && !ctl.clearing;
	assign push     = s_tvalid && s_tready;
	assign pop      = ctl.pop && q_valid;
	assign q_valid  = (fill_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end
endmodule

// ===== rtl/datks_back.sv =====
// ----------------------------------------------------------------------------
// Keyword scanner back end
// Trie walk sequencer: table writes, window replay, match reporting.
// ----------------------------------------------------------------------------
module datks_back #(
	parameter int TABLE_DEPTH    = datks_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_KEY_LENGTH = datks_pkg::MAX_KEY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  datks_pkg::item_t                    q_item,
	output datks_pkg::ctl_t                     ctl,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [datks_pkg::OUT_DATA_BITS-1:0] m_tdata,
	output logic                                m_tlast
);
	import datks_pkg::*;

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int WB  = $clog2(MAX_KEY_LENGTH);
	localparam int WIN = 1 << WB;
	localparam int LW  = $clog2(MAX_KEY_LENGTH + 1);
	localparam int PW  = ((AW > BASE_BITS) ? AW : BASE_BITS) + 3;
	localparam int CW  = BASE_BITS + 1;
	localparam logic [POSITION_BITS-1:0] POS_SAT = '1;

	state_t state_q, state_d;

	logic [AW-1:0]                clr_addr_q;
	logic signed [BASE_BITS-1:0]  root_base_q;
	logic signed [BASE_BITS-1:0]  walk_base_q;
	logic [LW-1:0]                depth_q;
	logic [LW-1:0]                best_q;
	logic [LW-1:0]                count_q;
	logic [WB-1:0]                head_q;
	logic [CHAR_BITS-1:0]         win_q [WIN];
	logic [POSITION_BITS-1:0]     offset_q;
	logic                         flush_q;
	logic                         term_ok_q;
	logic                         held_valid_q;
	logic [POSITION_BITS-1:0]     held_start_q;
	logic [LW-1:0]                held_len_q;
	logic                         out_valid_q;
	logic [POSITION_BITS-1:0]     out_start_q;
	logic [LW-1:0]                out_len_q;
	logic                         out_last_q;

	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	entry_t                       ram_wdata;
	logic [AW-1:0]                ram_raddr;
	logic [$bits(entry_t)-1:0]    ram_rdata;
	entry_t                       rd;

	logic [CHAR_BITS-1:0]         cur_chr;
	logic signed [BASE_BITS-1:0]  cur_base;
	logic signed [PW-1:0]         p;
	logic                         p_ok;
	logic                         chk_match;
	logic                         nb_ok;
	logic                         can_step;
	logic                         can_flush;
	logic                         out_free;
	logic                         emit_stall;
	logic                         fin_stall;
	logic                         out_load;
	logic [LW-1:0]                step;
	logic [POSITION_BITS:0]       off_sum;

	datks_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd = entry_t'(ram_rdata);

	// walk datapath
	always_comb begin
		cur_chr   = win_q[head_q + depth_q[WB-1:0]];
		cur_base  = (depth_q == '0) ? root_base_q : walk_base_q;
		p         = PW'(cur_base) + PW'($signed({1'b0, cur_chr})) + PW'(1);
		p_ok      = !p[PW-1] && (p < PW'(TABLE_DEPTH));
		chk_match = ($signed({2'b00, rd.check}) == CW'(walk_base_q));
		nb_ok     = !rd.base[BASE_BITS-1] && (32'(rd.base) < TABLE_DEPTH);
		can_step  = (depth_q < count_q);
		can_flush = (count_q != '0) &&
			(flush_q || (32'(depth_q) >= MAX_KEY_LENGTH));
		out_free  = !out_valid_q || m_tready;
		emit_stall = (best_q != '0) && held_valid_q && !out_free;
		fin_stall  = held_valid_q && !out_free;
		// held match moves to the output register
		out_load  = ((state_q == ST_RESOLVE) && !emit_stall && (best_q != '0) &&
			held_valid_q) || ((state_q == ST_FINISH) && !fin_stall && held_valid_q);
		step      = (best_q != '0) ? best_q : LW'(1);
		if (step > count_q) step = count_q;
		off_sum   = {1'b0, offset_q} + (POSITION_BITS+1)'(step);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (32'(clr_addr_q) == TABLE_DEPTH - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid && q_item.is_text) state_d = ST_ADV;
			end
			ST_ADV: begin
				if (can_step) state_d = p_ok ? ST_STEP : ST_RESOLVE;
				else if (can_flush) state_d = ST_RESOLVE;
				else state_d = ST_FINISH;
			end
			ST_STEP: begin
				if (!chk_match) state_d = ST_RESOLVE;
				else if (nb_ok) state_d = ST_TERM;
				else state_d = ST_ADV;
			end
			ST_TERM: state_d = ST_ADV;
			ST_RESOLVE: begin
				if (!emit_stall) state_d = ST_ADV;
			end
			ST_FINISH: begin
				if (!fin_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// table port and queue controls
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = clr_addr_q;
		ram_wdata    = '0;
		ram_raddr    = p[AW-1:0];
		ctl.pop      = 1'b0;
		ctl.clearing = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we       = 1'b1;
				ctl.clearing = 1'b1;
			end
			ST_IDLE: begin
				ctl.pop = q_valid;
				if (q_valid && !q_item.is_text && q_item.idx_ok) begin
					ram_we          = 1'b1;
					ram_waddr       = AW'(q_item.index);
					ram_wdata.base  = q_item.base;
					ram_wdata.check = q_item.check;
				end
			end
			ST_STEP: ram_raddr = AW'($unsigned(rd.base));
			default: ram_raddr = p[AW-1:0];
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			root_base_q  <= '0;
			walk_base_q  <= BASE_BITS'(1);
			depth_q      <= '0;
			best_q       <= '0;
			count_q      <= '0;
			head_q       <= '0;
			offset_q     <= '0;
			flush_q      <= 1'b0;
			term_ok_q    <= 1'b0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_addr_q <= clr_addr_q + 1'b1;
				ST_IDLE: begin
					if (q_valid && !q_item.is_text && q_item.index == '0) begin
						root_base_q <= q_item.base;
					end
					if (q_valid && q_item.is_text) begin
						flush_q <= q_item.eot;
						if (32'(count_q) < MAX_KEY_LENGTH) count_q <= count_q + 1'b1;
					end
				end
				ST_ADV: begin
					if (can_step) walk_base_q <= cur_base;
				end
				ST_STEP: begin
					term_ok_q <= nb_ok;
					if (chk_match) begin
						walk_base_q <= rd.base;
						depth_q     <= depth_q + 1'b1;
					end
				end
				ST_TERM: begin
					if (term_ok_q && chk_match && rd.base[BASE_BITS-1]) best_q <= depth_q;
				end
				ST_RESOLVE: begin
					if (!emit_stall) begin
						if (best_q != '0) begin
							held_valid_q <= 1'b1;
						end
						count_q  <= count_q - step;
						head_q   <= head_q + step[WB-1:0];
						offset_q <= off_sum[POSITION_BITS] ? POS_SAT : off_sum[POSITION_BITS-1:0];
						depth_q  <= '0;
						best_q   <= '0;
					end
				end
				ST_FINISH: begin
					if (!fin_stall) begin
						if (held_valid_q) begin
							held_valid_q <= 1'b0;
						end
						if (flush_q) begin
							count_q     <= '0;
							offset_q    <= '0;
							walk_base_q <= BASE_BITS'(1);
							depth_q     <= '0;
							best_q      <= '0;
						end
					end
				end
				default: clr_addr_q <= clr_addr_q;
			endcase
		end
	end

	// window and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && q_item.is_text &&
				32'(count_q) < MAX_KEY_LENGTH) begin
			win_q[head_q + count_q[WB-1:0]] <= q_item.chr;
		end
		if (state_q == ST_RESOLVE && !emit_stall && best_q != '0) begin
			held_start_q <= offset_q;
			held_len_q   <= best_q;
			if (held_valid_q) begin
				out_start_q <= held_start_q;
				out_len_q   <= held_len_q;
				out_last_q  <= 1'b0;
			end
		end
		if (state_q == ST_FINISH && !fin_stall && held_valid_q) begin
			out_start_q <= held_start_q;
			out_len_q   <= held_len_q;
			out_last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_DATA_BITS'({LEN_BITS'(out_len_q), out_start_q});
endmodule

// ===== rtl/double_array_trie_keyword_scanner.sv =====
// ----------------------------------------------------------------------------
// Double-array trie keyword scanner
// Streams text through a trie and reports longest keyword matches.
//
// Channel  Dir  Handshake          Contents
// s        in   s_tvalid/s_tready  table write or text character
// m        out  m_tvalid/m_tready  match start and length
//
// A table write is handled in the back end's idle state; a text character
// passes through intake, trie steps (advance, transition read, terminal
// read on the one table port), a resolve when a walk ends, the final
// advance check and finish.
// After reset the table is cleared, with s_tready low.
// A 4-word queue separates intake from the walk; a stalled m side holds
// the walk only when a second result is ready.
// ----------------------------------------------------------------------------
module double_array_trie_keyword_scanner #(
	parameter int TABLE_DEPTH    = datks_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_KEY_LENGTH = datks_pkg::MAX_KEY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// entry_index[15:0], entry_base[32:16], entry_check[48:33], char_code[64:49]
	input  logic [datks_pkg::IN_DATA_BITS-1:0]  s_tdata,
	// op
	input  logic                                s_tuser,
	// end_of_text
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// match_start[19:0], match_length[25:20]
	output logic [datks_pkg::OUT_DATA_BITS-1:0] m_tdata,
	// last
	output logic                                m_tlast
);
	import datks_pkg::*;

	`include "double_array_trie_keyword_scanner_macros.svh"

	ctl_t  ctl;
	logic  q_valid;
	item_t q_item;

	datks_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.ctl     (ctl),
		.q_valid (q_valid),
		.q_item  (q_item)
	);

	datks_back #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.MAX_KEY_LENGTH(MAX_KEY_LENGTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.ctl     (ctl),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// no intake while the table is being cleared
	`DATKS_ASSERT_NOW(a_clear_blocks, clk, arst_n, ctl.clearing, !s_tready)
	// a reported match is never empty
	`DATKS_ASSERT_NOW(a_len_nonzero, clk, arst_n, m_tvalid, m_tdata[25:20] != 6'd0)
	// no pop from an empty queue
	`DATKS_ASSERT_NOW(a_pop_valid, clk, arst_n, ctl.pop, q_valid)
	// clearing ends only into the idle state, never with a result pending
	`DATKS_ASSERT_NEXT(a_clear_quiet, clk, arst_n, ctl.clearing, !m_tvalid)
endmodule

// ===== bench/tb_double_array_trie_keyword_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword scanner testbench
// Loads a small keyword trie through the stream port, then streams text
// made of keywords and filler characters. An in-bench longest-match
// predictor queues the expected matches. Every match word that comes out is
// compared with the oldest queued match. Sender gaps and receiver stalls vary
// from phase to phase.
// ----------------------------------------------------------------------------
module tb_double_array_trie_keyword_scanner;
	import datks_pkg::*;

	localparam int  DEPTH    = TABLE_DEPTH_DEF;
	localparam int  MAX_KEY  = MAX_KEY_DEF;
	localparam int  NODE_SPC = 256;         // base spacing between trie nodes
	localparam int  ALPHA    = 4;           // keyword alphabet size
	localparam int  N_KEYS   = 8;
	localparam int  LIMIT    = 1500000;
	localparam bit  OP_WRITE = 1'b0;
	localparam bit  OP_TEXT  = 1'b1;
	localparam longint SAT   = (64'd1 << POSITION_BITS) - 1;

	typedef struct {
		bit        op;
		bit [15:0] idx;
		bit [16:0] base;
		bit [15:0] chk;
		bit [15:0] chr;
		bit        eot;
		bit        hold;    // wait for all matches before sending
	} scan_word_t;

	typedef struct {
		bit [19:0] start;
		bit [5:0]  len;
		bit        last;
	} match_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata = '0;
	logic                     s_tuser = 1'b0;
	logic                     s_tlast = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     m_tlast;

	double_array_trie_keyword_scanner dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	scan_word_t word_q[$];
	match_t     match_q[$];
	match_t     found_q[$];
	int         tx_idle_pct = 0;
	int         rx_stall_pct = 0;
	bit         failed = 1'b0;
	int         cyc = 0;

	// predictor state
	int     trie_base[DEPTH];
	int     trie_check[DEPTH];
	int     win[MAX_KEY];
	int     win_count = 0;
	longint win_start = 0;
	longint cur_base = 1;
	int     cur_depth = 0;
	int     best_len = 0;

	// stimulus trie bookkeeping
	int     kid[int];
	int     next_node = 2;
	int     kw[N_KEYS][6];
	int     kw_len[N_KEYS];

	function automatic bit in_trie(longint p);
		return p >= 0 && p < DEPTH;
	endfunction

	function automatic bit is_leaf(longint b);
		return in_trie(b) && longint'(trie_check[int'(b)]) == b && trie_base[int'(b)] < 0;
	endfunction

	function automatic bit walk_char(int c);
		longint p;
		if (cur_depth == 0) begin
			cur_base = trie_base[0];
			best_len = 0;
		end
		p = cur_base + c + 1;
		if (!in_trie(p) || longint'(trie_check[int'(p)]) != cur_base)
			return 1'b0;
		cur_base = trie_base[int'(p)];
		cur_depth++;
		if (is_leaf(cur_base))
			best_len = cur_depth;
		return 1'b1;
	endfunction

	// close the current walk, emit a match if any, slide the window
	function automatic void settle_window();
		int     adv;
		match_t m;
		adv = 1;
		if (best_len > 0) begin
			adv = best_len;
			m.start = win_start[19:0];
			m.len = best_len[5:0];
			m.last = 1'b0;
			found_q.push_back(m);
		end
		if (adv > win_count)
			adv = win_count;
		for (int i = 0; i < win_count - adv; i++)
			win[i] = win[i + adv];
		win_count -= adv;
		if (SAT - win_start < adv)
			win_start = SAT;
		else
			win_start += adv;
		cur_depth = 0;
		best_len = 0;
	endfunction

	function automatic void scan_word(scan_word_t w);
		if (w.op == OP_WRITE) begin
			trie_base[w.idx] = int'($signed(w.base));
			trie_check[w.idx] = int'(w.chk);
			return;
		end
		found_q.delete();
		if (win_count < MAX_KEY) begin
			win[win_count] = int'(w.chr);
			win_count++;
		end
		forever begin
			if (cur_depth < win_count) begin
				if (!walk_char(win[cur_depth]))
					settle_window();
			end else if (win_count > 0 && (w.eot || cur_depth >= MAX_KEY)) begin
				settle_window();
			end else begin
				break;
			end
		end
		if (w.eot) begin
			win_count = 0;
			win_start = 0;
			cur_base = 1;
			cur_depth = 0;
			best_len = 0;
		end
		if (found_q.size() > 0)
			found_q[$].last = 1'b1;
		foreach (found_q[i])
			match_q.push_back(found_q[i]);
	endfunction

	// sender: one word per handshake, predicted on acceptance
	scan_word_t cur_word;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				scan_word(cur_word);
			if (!s_tvalid || s_tready) begin
				if (word_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct &&
				    (!word_q[0].hold || match_q.size() == 0)) begin
					cur_word = word_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'b0, cur_word.chr, cur_word.chk, cur_word.base,
						cur_word.idx};
					s_tuser <= cur_word.op;
					s_tlast <= cur_word.eot;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: compare each match word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		match_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (match_q.size() == 0) begin
					$error("unexpected match word start=%0d len=%0d",
						m_tdata[19:0], m_tdata[25:20]);
					failed = 1'b1;
				end else begin
					e = match_q.pop_front();
					if (m_tdata[19:0] !== e.start) begin
						$error("match_start expected %0d got %0d", e.start, m_tdata[19:0]);
						failed = 1'b1;
					end
					if (m_tdata[25:20] !== e.len) begin
						$error("match_length expected %0d got %0d", e.len, m_tdata[25:20]);
						failed = 1'b1;
					end
					if (m_tlast !== e.last) begin
						$error("last expected %0d got %0d", e.last, m_tlast);
						failed = 1'b1;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic void add_write(int idx, int base, int chk, bit hold = 1'b0);
		scan_word_t w;
		w.op = OP_WRITE;
		w.idx = idx[15:0];
		w.base = base[16:0];
		w.chk = chk[15:0];
		w.chr = $urandom();
		w.eot = $urandom_range(0, 1);
		w.hold = hold;
		word_q.push_back(w);
	endfunction

	function automatic void add_char(int c, bit eot, bit hold = 1'b0);
		scan_word_t w;
		w.op = OP_TEXT;
		w.idx = $urandom();
		w.base = $urandom();
		w.chk = $urandom();
		w.chr = c[15:0];
		w.eot = eot;
		w.hold = hold;
		word_q.push_back(w);
	endfunction

	// insert one keyword into the trie, emitting the table writes
	function automatic void add_keyword(int k);
		int node, key, n;
		node = 1;
		for (int i = 0; i < kw_len[k]; i++) begin
			key = node * 16 + kw[k][i];
			if (!kid.exists(key)) begin
				n = next_node++;
				kid[key] = n;
				add_write(node * NODE_SPC + kw[k][i] + 1, n * NODE_SPC, node * NODE_SPC);
			end
			node = kid[key];
		end
		add_write(node * NODE_SPC, -$urandom_range(1, 65536), node * NODE_SPC);
	endfunction

	// text of keywords and filler, usually closed by end of text
	function automatic int add_sentence();
		int pieces, n, k;
		bit close;
		pieces = $urandom_range(1, 5);
		close = $urandom_range(0, 99) < 80;
		n = 0;
		for (int p = 0; p < pieces; p++) begin
			if ($urandom_range(0, 99) < 60) begin
				k = $urandom_range(0, N_KEYS - 1);
				for (int i = 0; i < kw_len[k]; i++) begin
					add_char(kw[k][i], close && p == pieces - 1 && i == kw_len[k] - 1);
					n++;
				end
			end else begin
				add_char($urandom_range(0, 99) < 15 ? $urandom_range(0, 65535) :
					$urandom_range(0, ALPHA - 1), close && p == pieces - 1);
				n++;
			end
		end
		return n;
	endfunction

	initial begin
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// keyword set and root
		for (int k = 0; k < N_KEYS; k++) begin
			kw_len[k] = $urandom_range(1, 5);
			for (int i = 0; i < kw_len[k]; i++)
				kw[k][i] = $urandom_range(0, ALPHA - 1);
		end
		add_write(0, NODE_SPC, 0);
		for (int k = 0; k < N_KEYS; k++)
			add_keyword(k);

		// directed: walks leaving the table above and below
		add_write(NODE_SPC + 9 + 1, 65530, NODE_SPC);
		add_write(NODE_SPC + 10 + 1, -65536, NODE_SPC);
		add_char(9, 1'b0);
		add_char(10, 1'b1);
		add_char(10, 1'b0);
		add_char(0, 1'b1);
		// extreme characters and every keyword on its own
		add_char(16'hFFFF, 1'b1);
		add_char(0, 1'b1);
		for (int k = 0; k < N_KEYS; k++)
			for (int i = 0; i < kw_len[k]; i++)
				add_char(kw[k][i], i == kw_len[k] - 1);
		// table write in the middle of a walk, then restore
		add_char(kw[0][0], 1'b0);
		add_write(NODE_SPC + kw[0][0] + 1, 0, 16'hFFFF);
		add_char(kw[0][0], 1'b1);
		add_write(NODE_SPC + kw[0][0] + 1, kid[16 + kw[0][0]] * NODE_SPC, NODE_SPC);
		// extreme entry fields at unused addresses
		add_write(16'h7FFF, 65535, 16'hFFFF);
		add_write(16'h8000, -65536, 0);

		// random phases with different idling
		for (int ph = 0; ph < 4; ph++) begin
			wait (word_q.size() == 0);
			tx_idle_pct = (ph == 1) ? 61 : (ph == 3) ? 19 : 0;
			rx_stall_pct = (ph == 2) ? 61 : (ph == 3) ? 19 : 0;
			n = 0;
			if (ph == 0) begin
				// empty root: unused entries chain until the window fills
				add_write(0, 0, 0);
				for (int i = 0; i < 36; i++)
					add_char($urandom_range(0, ALPHA - 1), i == 35);
				add_write(0, NODE_SPC, 0);
			end
			if (ph == 2)
				add_char(kw[1][0], 1'b1, 1'b1);
			while (n < 34) begin
				if ($urandom_range(0, 99) < 6) begin
					add_write($urandom_range(52000, 65535), $urandom_range(0, 131071) - 65536,
						$urandom_range(0, 65535));
					n++;
				end else begin
					n += add_sentence();
				end
			end
		end
		add_char(0, 1'b1);

		wait (word_q.size() == 0 && !s_tvalid);
		wait (match_q.size() == 0);
		repeat (400) @(posedge clk);
		if (match_q.size() > 0) begin
			$error("%0d expected matches never arrived", match_q.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
